>>> design/tsbg_pkg.sv
// Shared types and constants of the burst square-wave generator.
package tsbg_pkg;

  localparam int CfgW      = 16;
  localparam int CntW      = 16;
  localparam int SampleW   = 16;
  localparam int DivW      = 32;
  localparam int DivSteps  = 32;
  localparam int HalfSteps = 16;
  localparam int DivCntW   = 6;
  localparam int MulSteps  = 16;
  localparam int MulCntW   = 5;
  localparam int ProdW     = 32;

  localparam logic [15:0] Q15One    = 16'h7fff;
  localparam logic [15:0] Q15NegOne = 16'h8000;
  localparam logic [15:0] CntMax    = 16'hffff;

  typedef enum logic [2:0] {
    CFG_PERIOD = 3'd0,
    CFG_RISE   = 3'd1,
    CFG_FALL   = 3'd2,
    CFG_AMP    = 3'd3,
    CFG_OFFSET = 3'd4,
    CFG_BURST  = 3'd5,
    CFG_IDLE   = 3'd6,
    CFG_REPS   = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD_START,
    ST_DECIDE,
    ST_MOD_POS,
    ST_LEVEL,
    ST_RATIO,
    ST_MUL_GO,
    ST_MUL,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic            start;
    logic            half;
    logic [DivW-1:0] dividend;
    logic [15:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quo;
    logic [15:0]     rem;
  } div_rsp_t;

  typedef struct packed {
    logic        start;
    logic [15:0] a;
    logic [15:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             done;
    logic [ProdW-1:0] prod;
  } mul_rsp_t;

  // Counter increment that sticks at the all-ones value.
  function automatic logic [CntW-1:0] bump(input logic [CntW-1:0] c);
    logic [CntW-1:0] r;
    r = (c == CntMax) ? c : c + 16'd1;
    return r;
  endfunction

endpackage

>>> design/trapezoid_square_burst_generator.sv
// Top level of the burst square-wave generator with linear rise and fall edges.
//
//   Channel   Direction  Beat contents (lowest bit first)
//   s_axis    in         tdata: start_phase[15:0]; tuser: func
//   m_axis    out        tdata: sample[15:0]; tuser: in_burst, bursts_done
//   cfg       in         cfg_idx_i selects the register, cfg_data_i is written
//
// One item is worked on at a time. A tick at offset level needs only the bit-serial
// multiply; on the waveform it takes a 16-step phase modulo and, on the edge
// slopes, a 32-step division in the bit-serial divider, then a 16-step bit-serial
// multiply; a start item adds one more 16-step modulo for the loaded phase.
// Reset sets every counter to zero and the registers to their defaults.
// The next input beat is taken while the previous result still waits in the output
// register; the sequencer only stalls at its last step until that register is free.
module trapezoid_square_burst_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // start_phase[15:0]
  input  logic        s_axis_tuser,   // func (1 = start)
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // sample[15:0]
  output logic [1:0]  m_axis_tuser    // in_burst, bursts_done
);

  // Configuration registers.
  logic [15:0] period_q, rise_q, fall_q, amp_q, offset_q, burst_q, idle_len_q, reps_q;
  logic [15:0] p_eff, rise_eff, fall_eff;

  // Generator state, cleared by reset.
  logic [15:0] wave_pos_q, seg_pos_q, rep_cnt_q, loaded_q;
  logic        idle_ph_q;

  // Per-item working registers.
  logic        active_q, fin_q, reload_q, neg_q;
  logic [15:0] x_q, z_q;

  // Output register.
  logic        out_valid_q;
  logic [15:0] out_sample_q;
  logic        out_active_q, out_fin_q;

  tsbg_pkg::state_e   state_q, state_d;
  tsbg_pkg::div_req_t div_req;
  tsbg_pkg::div_rsp_t div_rsp;
  tsbg_pkg::mul_req_t mul_req;
  tsbg_pkg::mul_rsp_t mul_rsp;

  logic accept, can_emit;

  assign p_eff    = (period_q == 16'd0) ? 16'd1 : period_q;
  assign rise_eff = (rise_q == 16'd0) ? 16'd1 : rise_q;
  assign fall_eff = (fall_q == 16'd0) ? 16'd1 : fall_q;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign can_emit = !out_valid_q || m_axis_tready;

  // ---------------------------------------------------------------------------
  // Burst bookkeeping. Decided once per item before the waveform is worked out.
  // ---------------------------------------------------------------------------
  logic [15:0] seg_inc, rep_inc;
  logic        burst_on, finished, wave_d, seg_end_burst, seg_end_idle;

  assign seg_inc       = tsbg_pkg::bump(seg_pos_q);
  assign rep_inc       = tsbg_pkg::bump(rep_cnt_q);
  assign burst_on      = (burst_q != 16'd0);
  assign finished      = (rep_cnt_q >= reps_q);
  assign wave_d        = !burst_on || (!finished && !idle_ph_q);
  assign seg_end_burst = (seg_inc >= burst_q);
  assign seg_end_idle  = (seg_inc >= idle_len_q);

  // Phase advance after a waveform sample: wraps at the period.
  logic [16:0] pos_inc;
  logic [15:0] pos_next;

  assign pos_inc  = {1'b0, div_rsp.rem} + 17'd1;
  assign pos_next = (pos_inc >= {1'b0, p_eff}) ? 16'd0 : pos_inc[15:0];

  // ---------------------------------------------------------------------------
  // Level classification of the phase x. Five segments: rising half edge, high,
  // falling edge, low, and the second half of the rising edge.
  // ---------------------------------------------------------------------------
  logic signed [17:0] xs, h_s, f_s, pmf, pmf_adj, t1, t2, t3, n_c;
  logic        [16:0] two_x, mag;
  logic        [15:0] lvl_z, lvl_den;
  logic               lvl_div, lvl_neg;
  logic        [31:0] lvl_dividend;

  assign xs      = {2'b00, x_q};
  assign h_s     = {3'b000, rise_eff[15:1]};
  assign f_s     = {2'b00, fall_eff};
  assign pmf     = {2'b00, p_eff} - f_s;
  // Halving toward zero for a negative difference.
  assign pmf_adj = pmf + {17'd0, pmf[17]};
  assign t1      = pmf_adj >>> 1;
  assign t2      = ({2'b00, p_eff} + f_s) >>> 1;
  assign t3      = {2'b00, p_eff} - h_s;
  assign two_x   = {x_q, 1'b0};
  assign n_c     = {2'b00, p_eff} - {1'b0, two_x};

  always_comb begin
    lvl_z   = '0;
    lvl_div = 1'b0;
    lvl_neg = 1'b0;
    lvl_den = rise_eff;
    mag     = two_x;
    priority if (xs < h_s) begin
      lvl_div = 1'b1;
    end else if (xs < t1) begin
      lvl_z = tsbg_pkg::Q15One;
    end else if (xs < t2) begin
      lvl_den = fall_eff;
      priority if (fall_eff <= 16'd1) begin
        lvl_z = '0;
      end else if (n_c >= f_s) begin
        lvl_z = tsbg_pkg::Q15One;
      end else begin
        lvl_div = 1'b1;
        lvl_neg = n_c[17];
        mag     = n_c[17] ? 17'(-n_c) : n_c[16:0];
      end
    end else if (xs < t3) begin
      lvl_z = tsbg_pkg::Q15NegOne;
    end else begin
      lvl_div = 1'b1;
      lvl_neg = 1'b1;
      mag     = {p_eff, 1'b0} - two_x;
    end
  end

  // Rounded ratio: (mag * 32768 + den / 2) / den.
  assign lvl_dividend = {mag, 15'd0} + {17'd0, lvl_den[15:1]};

  // Saturate the quotient into Q1.15 and apply the sign.
  logic [15:0] ratio_z;

  always_comb begin
    if (neg_q) begin
      ratio_z = (div_rsp.quo >= 32'd32768) ? tsbg_pkg::Q15NegOne
                                           : (~div_rsp.quo[15:0]) + 16'd1;
    end else begin
      ratio_z = (div_rsp.quo > 32'd32767) ? tsbg_pkg::Q15One : div_rsp.quo[15:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Final scaling: offset + round(amplitude * z / 32768), saturated.
  // ---------------------------------------------------------------------------
  logic signed [32:0] rnd;
  logic signed [17:0] scaled;
  logic signed [18:0] sum;
  logic        [15:0] sample_sat;

  assign rnd    = $signed({mul_rsp.prod[31], mul_rsp.prod}) + 33'sd16384;
  assign scaled = rnd[32:15];
  assign sum    = {{3{offset_q[15]}}, offset_q} + {scaled[17], scaled};

  always_comb begin
    priority if (sum > 19'sd32767) begin
      sample_sat = tsbg_pkg::Q15One;
    end else if (sum < -19'sd32768) begin
      sample_sat = tsbg_pkg::Q15NegOne;
    end else begin
      sample_sat = sum[15:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tsbg_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = s_axis_tuser ? tsbg_pkg::ST_MOD_START : tsbg_pkg::ST_DECIDE;
        end
      end
      tsbg_pkg::ST_MOD_START: begin
        if (div_rsp.done) begin
          state_d = tsbg_pkg::ST_DECIDE;
        end
      end
      tsbg_pkg::ST_DECIDE: begin
        state_d = wave_d ? tsbg_pkg::ST_MOD_POS : tsbg_pkg::ST_MUL_GO;
      end
      tsbg_pkg::ST_MOD_POS: begin
        if (div_rsp.done) begin
          state_d = tsbg_pkg::ST_LEVEL;
        end
      end
      tsbg_pkg::ST_LEVEL: begin
        state_d = lvl_div ? tsbg_pkg::ST_RATIO : tsbg_pkg::ST_MUL_GO;
      end
      tsbg_pkg::ST_RATIO: begin
        if (div_rsp.done) begin
          state_d = tsbg_pkg::ST_MUL_GO;
        end
      end
      tsbg_pkg::ST_MUL_GO: begin
        state_d = tsbg_pkg::ST_MUL;
      end
      tsbg_pkg::ST_MUL: begin
        if (mul_rsp.done) begin
          state_d = tsbg_pkg::ST_EMIT;
        end
      end
      tsbg_pkg::ST_EMIT: begin
        if (can_emit) begin
          state_d = tsbg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tsbg_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: outputs. The divider serves three jobs: the start phase modulo,
  // the running phase modulo and the slope ratio.
  // ---------------------------------------------------------------------------
  always_comb begin
    s_axis_tready    = 1'b0;
    div_req.start    = 1'b0;
    div_req.half     = 1'b1;
    div_req.dividend = {16'd0, wave_pos_q};
    div_req.divisor  = p_eff;
    mul_req.start    = 1'b0;
    mul_req.a        = amp_q;
    mul_req.b        = z_q;
    unique case (state_q)
      tsbg_pkg::ST_IDLE: begin
        s_axis_tready    = 1'b1;
        div_req.start    = accept && s_axis_tuser;
        div_req.dividend = {16'd0, s_axis_tdata};
      end
      tsbg_pkg::ST_DECIDE: begin
        div_req.start = wave_d;
      end
      tsbg_pkg::ST_LEVEL: begin
        div_req.start    = lvl_div;
        div_req.half     = 1'b0;
        div_req.dividend = lvl_dividend;
        div_req.divisor  = lvl_den;
      end
      tsbg_pkg::ST_MUL_GO: begin
        mul_req.start = 1'b1;
      end
      tsbg_pkg::ST_MOD_START, tsbg_pkg::ST_MOD_POS, tsbg_pkg::ST_RATIO,
      tsbg_pkg::ST_MUL, tsbg_pkg::ST_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  tsbg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  tsbg_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  // ---------------------------------------------------------------------------
  // Control registers: sequencer, configuration, counters and output valid.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tsbg_pkg::ST_IDLE;
      period_q    <= 16'd1;
      rise_q      <= 16'd1;
      fall_q      <= 16'd1;
      amp_q       <= '0;
      offset_q    <= '0;
      burst_q     <= '0;
      idle_len_q  <= '0;
      reps_q      <= '0;
      wave_pos_q  <= '0;
      seg_pos_q   <= '0;
      rep_cnt_q   <= '0;
      loaded_q    <= '0;
      idle_ph_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (tsbg_pkg::cfg_idx_e'(cfg_idx_i))
          tsbg_pkg::CFG_PERIOD: period_q   <= cfg_data_i;
          tsbg_pkg::CFG_RISE:   rise_q     <= cfg_data_i;
          tsbg_pkg::CFG_FALL:   fall_q     <= cfg_data_i;
          tsbg_pkg::CFG_AMP:    amp_q      <= cfg_data_i;
          tsbg_pkg::CFG_OFFSET: offset_q   <= cfg_data_i;
          tsbg_pkg::CFG_BURST:  burst_q    <= cfg_data_i;
          tsbg_pkg::CFG_IDLE:   idle_len_q <= cfg_data_i;
          tsbg_pkg::CFG_REPS:   reps_q     <= cfg_data_i;
          default: begin
          end
        endcase
      end

      // A start item restarts the burst pattern at the reduced phase.
      if (state_q == tsbg_pkg::ST_MOD_START && div_rsp.done) begin
        loaded_q   <= div_rsp.rem;
        wave_pos_q <= div_rsp.rem;
        seg_pos_q  <= '0;
        rep_cnt_q  <= '0;
        idle_ph_q  <= 1'b0;
      end

      // Segment counting for burst mode; continuous mode and the finished
      // pattern leave the counters alone.
      if (state_q == tsbg_pkg::ST_DECIDE && burst_on && !finished) begin
        if (!idle_ph_q) begin
          if (seg_end_burst) begin
            seg_pos_q <= '0;
            if (idle_len_q == 16'd0) begin
              rep_cnt_q <= rep_inc;
            end else begin
              idle_ph_q <= 1'b1;
            end
          end else begin
            seg_pos_q <= seg_inc;
          end
        end else begin
          if (seg_end_idle) begin
            seg_pos_q <= '0;
            idle_ph_q <= 1'b0;
            rep_cnt_q <= rep_inc;
          end else begin
            seg_pos_q <= seg_inc;
          end
        end
      end

      // The end of a burst sends the phase back to the loaded phase.
      if (state_q == tsbg_pkg::ST_MOD_POS && div_rsp.done) begin
        wave_pos_q <= reload_q ? loaded_q : pos_next;
      end

      if (state_q == tsbg_pkg::ST_EMIT && can_emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Working and output data registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      tsbg_pkg::ST_DECIDE: begin
        active_q <= wave_d;
        fin_q    <= burst_on && finished;
        reload_q <= burst_on && !finished && !idle_ph_q && seg_end_burst;
        z_q      <= '0;
      end
      tsbg_pkg::ST_MOD_POS: begin
        if (div_rsp.done) begin
          x_q <= div_rsp.rem;
        end
      end
      tsbg_pkg::ST_LEVEL: begin
        z_q   <= lvl_z;
        neg_q <= lvl_neg;
      end
      tsbg_pkg::ST_RATIO: begin
        if (div_rsp.done) begin
          z_q <= ratio_z;
        end
      end
      tsbg_pkg::ST_EMIT: begin
        if (can_emit) begin
          out_sample_q <= sample_sat;
          out_active_q <= active_q;
          out_fin_q    <= fin_q;
        end
      end
      tsbg_pkg::ST_IDLE, tsbg_pkg::ST_MOD_START, tsbg_pkg::ST_MUL_GO,
      tsbg_pkg::ST_MUL: begin
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_sample_q;
  assign m_axis_tuser  = {out_fin_q, out_active_q};

endmodule

>>> design/tsbg_div.sv
// Bit-serial restoring divider giving quotient and remainder, one bit per cycle.
module tsbg_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tsbg_pkg::div_req_t req_i,
  output tsbg_pkg::div_rsp_t rsp_o
);

  logic                           run_q, run_d;
  logic                           done_q, done_d;
  logic [tsbg_pkg::DivCntW-1:0]   cnt_q, cnt_d;
  logic [tsbg_pkg::DivW-1:0]      dvd_q, dvd_d;
  logic [15:0]                    rem_q, rem_d;
  logic [15:0]                    dvs_q, dvs_d;
  logic [16:0]                    rem_sh;
  logic [17:0]                    diff;
  logic                           ge;

  assign rem_sh = {rem_q, dvd_q[tsbg_pkg::DivW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
  assign ge     = ~diff[17];

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      run_d = 1'b1;
      dvs_d = req_i.divisor;
      rem_d = '0;
      if (req_i.half) begin
        // A 16-bit dividend is left aligned so the top bits feed the loop.
        dvd_d = {req_i.dividend[15:0], 16'h0000};
        cnt_d = tsbg_pkg::DivCntW'(tsbg_pkg::HalfSteps);
      end else begin
        dvd_d = req_i.dividend;
        cnt_d = tsbg_pkg::DivCntW'(tsbg_pkg::DivSteps);
      end
    end else if (run_q) begin
      rem_d = ge ? diff[15:0] : rem_sh[15:0];
      dvd_d = {dvd_q[tsbg_pkg::DivW-2:0], ge};
      cnt_d = cnt_q - tsbg_pkg::DivCntW'(1);
      if (cnt_q == tsbg_pkg::DivCntW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  // In half mode the quotient sits in the low 16 bits.
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = dvd_q;
  assign rsp_o.rem  = rem_q;

endmodule

>>> design/tsbg_mul.sv
// Bit-serial signed shift-and-add multiplier, one multiplier bit per cycle.
module tsbg_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tsbg_pkg::mul_req_t req_i,
  output tsbg_pkg::mul_rsp_t rsp_o
);

  logic                           run_q, run_d;
  logic                           done_q, done_d;
  logic [tsbg_pkg::MulCntW-1:0]   cnt_q, cnt_d;
  logic [tsbg_pkg::ProdW-1:0]     mcand_q, mcand_d;
  logic [15:0]                    mplier_q, mplier_d;
  logic [tsbg_pkg::ProdW-1:0]     acc_q, acc_d;
  logic [tsbg_pkg::ProdW-1:0]     addend;

  assign addend = mplier_q[0] ? mcand_q : '0;

  always_comb begin
    run_d    = run_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    acc_d    = acc_q;
    if (req_i.start) begin
      run_d    = 1'b1;
      cnt_d    = tsbg_pkg::MulCntW'(tsbg_pkg::MulSteps);
      mcand_d  = {{16{req_i.a[15]}}, req_i.a};
      mplier_d = req_i.b;
      acc_d    = '0;
    end else if (run_q) begin
      // The sign bit of the multiplier carries negative weight.
      if (cnt_q == tsbg_pkg::MulCntW'(1)) begin
        acc_d  = acc_q - addend;
        run_d  = 1'b0;
        done_d = 1'b1;
      end else begin
        acc_d = acc_q + addend;
      end
      mcand_d  = {mcand_q[tsbg_pkg::ProdW-2:0], 1'b0};
      mplier_d = {1'b0, mplier_q[15:1]};
      cnt_d    = cnt_q - tsbg_pkg::MulCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    acc_q    <= acc_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

endmodule

>>> tb/trapezoid_square_burst_generator_tb.sv
// Self-checking testbench for the burst square-wave generator with sloped edges.
`timescale 1ns / 100ps

module trapezoid_square_burst_generator_tb;

  // Input beat kinds carried on s_axis_tuser.
  localparam bit FUNC_TICK  = 1'b0;
  localparam bit FUNC_START = 1'b1;

  // Stimulus size, quiet-cycle limit and the settle time used before register writes.
  localparam int ItemTarget = 1450;
  localparam int QuietLimit = 10000;
  localparam int SettleCyc  = 100;
  localparam int MaxReports = 10;

  // One output beat as the checker sees it.
  typedef struct packed {
    logic [15:0] sample;
    logic        in_burst;
    logic        bursts_done;
  } gen_beat_t;

  // One row of the directed script: either a register write or an input beat.
  // Rows flagged as typed carry a hand-written expectation instead of the predicted one.
  typedef struct {
    bit                 is_write;
    tsbg_pkg::cfg_idx_e reg_idx;
    logic [15:0]        reg_val;
    bit                 func;
    logic [15:0]        phase;
    bit                 typed;
    gen_beat_t          want;
  } script_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // start_phase[15:0]
  logic        s_axis_tuser;   // func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;   // sample[15:0]
  logic [1:0]  m_axis_tuser;   // in_burst, bursts_done

  always #1 clk_i = ~clk_i;

  trapezoid_square_burst_generator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // ---------------------------------------------------------------------------
  // Predictor: a shadow copy of the registers and the burst counters.
  // ---------------------------------------------------------------------------
  logic [15:0]        cur_period, cur_rise, cur_fall;
  logic signed [15:0] cur_amp, cur_offset;
  logic [15:0]        cur_burst, cur_idle, cur_reps;
  logic [15:0]        wave_pos, seg_pos, rep_cnt, loaded_pos;
  bit                 in_idle;

  gen_beat_t owed_beats[$];   // predicted beats not yet seen on the output
  script_row_t script[$];

  int gap_pct   = 0;          // chance in percent that the sender idles a cycle
  int stall_pct = 0;          // chance in percent that the receiver stalls a cycle
  int n_items, n_starts, n_results, n_mismatch, n_settings;

  // Lengths of zero behave as one.
  function automatic longint nonzero(logic [15:0] v);
    return (v == 16'd0) ? 64'sd1 : longint'(v);
  endfunction

  function automatic logic [15:0] sat_inc(logic [15:0] c);
    return (c == 16'hffff) ? c : c + 16'd1;
  endfunction

  // num/den in Q1.15, rounded half away from zero and clamped to the Q1.15 range.
  function automatic longint edge_fraction(longint num, longint den);
    longint mag, q;
    mag = ((num < 0) ? -num : num) * 32768;
    q   = (mag + den / 2) / den;
    if (num < 0) q = -q;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q;
  endfunction

  // Normalized level at position x of one period: rising ramp centered on x = 0,
  // high plateau, falling ramp centered on p/2, low plateau, then the rise again.
  function automatic longint shape_level(longint x, longint p, longint rise, longint fall);
    longint h;
    h = rise / 2;
    if (x < h) return edge_fraction(2 * x, rise);
    if (x < (p - fall) / 2) return 32767;
    if (x < (p + fall) / 2) begin
      if (fall <= 1) return 0;
      if (p - 2 * x >= fall) return 32767;
      return edge_fraction(p - 2 * x, fall);
    end
    if (x < p - h) return -32768;
    return edge_fraction(2 * x - 2 * p, rise);
  endfunction

  // offset + amplitude * z / 32768, the product rounded half up, clamped to 16 bits.
  function automatic logic [15:0] level_to_code(longint z);
    longint s;
    s = longint'(cur_offset) + ((longint'(cur_amp) * z + 16384) >>> 15);
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    return 16'(s);
  endfunction

  // Waveform code at the current phase; the phase then moves on by one sample.
  function automatic logic [15:0] wave_code();
    longint p, x;
    logic [15:0] code;
    p    = nonzero(cur_period);
    x    = longint'(wave_pos) % p;
    code = level_to_code(shape_level(x, p, nonzero(cur_rise), nonzero(cur_fall)));
    x++;
    if (x >= p) x = 0;
    wave_pos = 16'(x);
    return code;
  endfunction

  // Advance the burst sequencer by one input beat and return the beat it emits.
  task automatic advance_generator(input bit f, input logic [15:0] ph, output gen_beat_t r);
    if (f == FUNC_START) begin
      loaded_pos = 16'(longint'(ph) % nonzero(cur_period));
      wave_pos   = loaded_pos;
      seg_pos    = '0;
      rep_cnt    = '0;
      in_idle    = 1'b0;
    end
    r = '0;
    if (cur_burst == 16'd0) begin
      // Continuous mode: the burst counters stay where they are.
      r.sample   = wave_code();
      r.in_burst = 1'b1;
    end else if (rep_cnt >= cur_reps) begin
      r.sample      = level_to_code(0);
      r.bursts_done = 1'b1;
    end else if (!in_idle) begin
      r.sample   = wave_code();
      r.in_burst = 1'b1;
      seg_pos    = sat_inc(seg_pos);
      if (seg_pos >= cur_burst) begin
        // End of a burst: the phase restarts where the start record put it.
        seg_pos  = '0;
        wave_pos = loaded_pos;
        if (cur_idle == 16'd0) rep_cnt = sat_inc(rep_cnt);
        else in_idle = 1'b1;
      end
    end else begin
      r.sample = level_to_code(0);
      seg_pos  = sat_inc(seg_pos);
      if (seg_pos >= cur_idle) begin
        seg_pos = '0;
        in_idle = 1'b0;
        rep_cnt = sat_inc(rep_cnt);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Bus drivers.
  // ---------------------------------------------------------------------------

  // Register write as a one-cycle write-enable strobe; the enable is low again before the task returns.
  task automatic write_reg(input tsbg_pkg::cfg_idx_e idx, input logic [15:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      tsbg_pkg::CFG_PERIOD: cur_period = v;
      tsbg_pkg::CFG_RISE:   cur_rise   = v;
      tsbg_pkg::CFG_FALL:   cur_fall   = v;
      tsbg_pkg::CFG_AMP:    cur_amp    = v;
      tsbg_pkg::CFG_OFFSET: cur_offset = v;
      tsbg_pkg::CFG_BURST:  cur_burst  = v;
      tsbg_pkg::CFG_IDLE:   cur_idle   = v;
      tsbg_pkg::CFG_REPS:   cur_reps   = v;
      default: ;
    endcase
  endtask

  // Hold off the sender until every owed beat has come back, then let the block settle.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (owed_beats.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  // Present one input beat, after a random gap, and return the predicted output beat.
  // The valid stays high on return so that back-to-back beats need no second assignment.
  task automatic send_item(input bit f, input logic [15:0] ph, output gen_beat_t predicted);
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ph;
    s_axis_tuser  <= f;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    advance_generator(f, ph, predicted);
    n_items++;
    if (f == FUNC_START) n_starts++;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random back-pressure and the field-by-field check.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    gen_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (owed_beats.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= MaxReports)
          $display("%0t: unexpected output beat sample=%h tuser=%b",
                   $realtime, m_axis_tdata, m_axis_tuser);
      end else begin
        want = owed_beats.pop_front();
        if (m_axis_tdata !== want.sample || m_axis_tuser[0] !== want.in_burst ||
            m_axis_tuser[1] !== want.bursts_done) begin
          n_mismatch++;
          if (n_mismatch <= MaxReports)
            $display("%0t: beat %0d expected sample=%h in_burst=%b done=%b, got %h %b %b",
                     $realtime, n_results, want.sample, want.in_burst, want.bursts_done,
                     m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]);
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: give up when neither side has moved a beat for too long.
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("Timeout after %0d cycles without a beat, %0d beats still owed",
                 quiet_cycles, owed_beats.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed script builders.
  // ---------------------------------------------------------------------------
  function automatic void add_write(tsbg_pkg::cfg_idx_e idx, logic [15:0] v);
    script_row_t r;
    r.is_write = 1'b1;
    r.reg_idx  = idx;
    r.reg_val  = v;
    r.func     = FUNC_TICK;
    r.phase    = '0;
    r.typed    = 1'b0;
    r.want     = '0;
    script.push_back(r);
  endfunction

  function automatic void add_item(bit f, logic [15:0] ph);
    script_row_t r;
    r.is_write = 1'b0;
    r.reg_idx  = tsbg_pkg::CFG_PERIOD;
    r.reg_val  = '0;
    r.func     = f;
    r.phase    = ph;
    r.typed    = 1'b0;
    r.want     = '0;
    script.push_back(r);
  endfunction

  function automatic void add_checked(bit f, logic [15:0] ph, logic [15:0] smp, bit inb,
                                      bit done);
    script_row_t r;
    r.is_write = 1'b0;
    r.reg_idx  = tsbg_pkg::CFG_PERIOD;
    r.reg_val  = '0;
    r.func     = f;
    r.phase    = ph;
    r.typed    = 1'b1;
    r.want     = '{sample: smp, in_burst: inb, bursts_done: done};
    script.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    gen_beat_t beat;
    logic [15:0] v_period, v_rise, v_fall, v_amp, v_offset, v_burst, v_idle, v_reps;
    logic [15:0] ph;
    bit f;
    int phase_no, n_phase_items, pick;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FUNC_TICK;
    cur_period = 16'd1; cur_rise = 16'd1; cur_fall = 16'd1;
    cur_amp = '0; cur_offset = '0; cur_burst = '0; cur_idle = '0; cur_reps = '0;
    wave_pos = '0; seg_pos = '0; rep_cnt = '0; loaded_pos = '0; in_idle = 1'b0;

    // A tick before any start runs from the reset state; with the reset registers
    // (zero amplitude and offset, continuous mode) every sample is zero and in the burst.
    add_checked(FUNC_TICK, 16'h0000, 16'h0000, 1'b1, 1'b0);
    add_checked(FUNC_START, 16'hffff, 16'h0000, 1'b1, 1'b0);

    // A short period with two-sample edges walks every segment of the shape.
    add_write(tsbg_pkg::CFG_PERIOD, 16'd8);
    add_write(tsbg_pkg::CFG_RISE, 16'd2);
    add_write(tsbg_pkg::CFG_FALL, 16'd2);
    add_write(tsbg_pkg::CFG_AMP, 16'h7fff);
    add_write(tsbg_pkg::CFG_OFFSET, 16'h0000);
    add_item(FUNC_START, 16'd0);
    repeat (7) add_item(FUNC_TICK, 16'd0);

    // Extreme amplitude on the low plateau pushes past the top and saturates.
    add_write(tsbg_pkg::CFG_AMP, 16'h8000);
    add_write(tsbg_pkg::CFG_OFFSET, 16'h7fff);
    add_checked(FUNC_START, 16'd5, 16'h7fff, 1'b1, 1'b0);
    // And the mirror case on the high plateau saturates at the bottom.
    add_write(tsbg_pkg::CFG_OFFSET, 16'h8000);
    add_checked(FUNC_START, 16'd1, 16'h8000, 1'b1, 1'b0);
    // A start phase beyond the period wraps around.
    add_item(FUNC_START, 16'hffff);

    // Gated bursts: two waveform samples, one idle sample, then all bursts done.
    add_write(tsbg_pkg::CFG_AMP, 16'h4000);
    add_write(tsbg_pkg::CFG_OFFSET, 16'h0000);
    add_write(tsbg_pkg::CFG_BURST, 16'd2);
    add_write(tsbg_pkg::CFG_IDLE, 16'd1);
    add_write(tsbg_pkg::CFG_REPS, 16'd1);
    add_item(FUNC_START, 16'd2);
    add_item(FUNC_TICK, 16'd0);
    add_checked(FUNC_TICK, 16'd0, 16'h0000, 1'b0, 1'b0);
    add_checked(FUNC_TICK, 16'd0, 16'h0000, 1'b0, 1'b1);

    // Without idle samples the next burst follows at once.
    add_write(tsbg_pkg::CFG_IDLE, 16'd0);
    add_write(tsbg_pkg::CFG_REPS, 16'd2);
    add_item(FUNC_START, 16'd3);
    repeat (3) add_item(FUNC_TICK, 16'd0);
    add_checked(FUNC_TICK, 16'd0, 16'h0000, 1'b0, 1'b1);

    // Zero repetitions: nothing but offset, flagged as done.
    add_write(tsbg_pkg::CFG_REPS, 16'd0);
    add_write(tsbg_pkg::CFG_OFFSET, 16'd1234);
    add_checked(FUNC_START, 16'd0, 16'd1234, 1'b0, 1'b1);

    // A phase left over from a longer period is wrapped into the new one.
    add_write(tsbg_pkg::CFG_BURST, 16'd0);
    add_write(tsbg_pkg::CFG_PERIOD, 16'd8);
    add_item(FUNC_START, 16'd5);
    add_write(tsbg_pkg::CFG_PERIOD, 16'd3);
    add_item(FUNC_TICK, 16'd0);

    // Zero period and edge lengths act as one: the only sample sits on the fall, level 0.
    add_write(tsbg_pkg::CFG_PERIOD, 16'd0);
    add_write(tsbg_pkg::CFG_RISE, 16'd0);
    add_write(tsbg_pkg::CFG_FALL, 16'd0);
    add_write(tsbg_pkg::CFG_AMP, 16'h7fff);
    add_write(tsbg_pkg::CFG_OFFSET, 16'd100);
    add_checked(FUNC_START, 16'd77, 16'd100, 1'b1, 1'b0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, no idling on either side.
    n_settings = 1;
    foreach (script[k]) begin
      if (script[k].is_write) begin
        if (k == 0 || !script[k - 1].is_write) begin
          wait_drained();
          n_settings++;
        end
        write_reg(script[k].reg_idx, script[k].reg_val);
      end else begin
        send_item(script[k].func, script[k].phase, beat);
        if (script[k].typed) beat = script[k].want;
        owed_beats.push_back(beat);
      end
    end

    // Random part: each phase loads a fresh register set while the block is idle, then
    // plays a run of beats that mostly ticks the sequencer along after a start record.
    phase_no = 0;
    while (n_items < ItemTarget) begin
      wait_drained();
      case (phase_no)
        0: begin
          v_period = 16'hffff; v_rise = 16'hffff; v_fall = 16'hffff;
          v_amp = 16'h7fff; v_offset = 16'h7fff;
          v_burst = 16'hffff; v_idle = 16'hffff; v_reps = 16'hffff;
        end
        1: begin
          v_period = 16'd1; v_rise = 16'd1; v_fall = 16'd1;
          v_amp = 16'h8000; v_offset = 16'h0000;
          v_burst = 16'd1; v_idle = 16'd0; v_reps = 16'd1;
        end
        default: begin
          pick = $urandom_range(99);
          v_period = (pick < 5) ? 16'd0 : (pick < 10) ? 16'hffff :
                     (pick < 15) ? 16'($urandom) : 16'($urandom_range(1, 40));
          pick = $urandom_range(99);
          v_rise = (pick < 5) ? 16'd0 : (pick < 10) ? 16'hffff :
                   (pick < 20) ? 16'($urandom_range(1, 2)) : 16'($urandom_range(1, 44));
          pick = $urandom_range(99);
          v_fall = (pick < 5) ? 16'd0 : (pick < 10) ? 16'hffff :
                   (pick < 20) ? 16'($urandom_range(1, 2)) : 16'($urandom_range(1, 44));
          pick = $urandom_range(99);
          v_amp = (pick < 10) ? 16'h8000 : (pick < 20) ? 16'h7fff : 16'($urandom);
          pick = $urandom_range(99);
          v_offset = (pick < 10) ? 16'h8000 : (pick < 20) ? 16'h7fff :
                     (pick < 30) ? 16'h0000 : 16'($urandom);
          pick = $urandom_range(99);
          v_burst = (pick < 30) ? 16'd0 : (pick < 35) ? 16'hffff :
                    16'($urandom_range(1, 12));
          pick = $urandom_range(99);
          v_idle = (pick < 25) ? 16'd0 : (pick < 30) ? 16'hffff : 16'($urandom_range(1, 8));
          pick = $urandom_range(99);
          v_reps = (pick < 15) ? 16'd0 : (pick < 20) ? 16'hffff : 16'($urandom_range(1, 6));
        end
      endcase
      write_reg(tsbg_pkg::CFG_PERIOD, v_period);
      write_reg(tsbg_pkg::CFG_RISE, v_rise);
      write_reg(tsbg_pkg::CFG_FALL, v_fall);
      write_reg(tsbg_pkg::CFG_AMP, v_amp);
      write_reg(tsbg_pkg::CFG_OFFSET, v_offset);
      write_reg(tsbg_pkg::CFG_BURST, v_burst);
      write_reg(tsbg_pkg::CFG_IDLE, v_idle);
      write_reg(tsbg_pkg::CFG_REPS, v_reps);
      n_settings++;

      // Cycle through the idling patterns: none, sender, receiver, both.
      case (phase_no % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 71; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 71; end
        default: begin gap_pct = 31; stall_pct = 31; end
      endcase

      n_phase_items = $urandom_range(30, 90);
      for (int i = 0; i < n_phase_items; i++) begin
        f  = (i == 0) ? ($urandom_range(99) < 85) : ($urandom_range(99) < 6);
        ph = ($urandom_range(1) == 1) ? 16'($urandom) : 16'($urandom_range(0, 40));
        // Now and then the sender waits for the output to catch up completely.
        if ($urandom_range(99) < 2) wait_drained();
        send_item(f, ph, beat);
        owed_beats.push_back(beat);
      end
      phase_no++;
    end

    s_axis_tvalid <= 1'b0;
    while (owed_beats.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);

    $display("Ran %0d input beats (%0d start records) over %0d register settings;",
             n_items, n_starts, n_settings);
    $display("checked %0d output beats, %0d mismatches.", n_results, n_mismatch);
    if (n_mismatch == 0 && owed_beats.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> trapezoid_square_burst_generator.f
design/tsbg_pkg.sv
design/tsbg_div.sv
design/tsbg_mul.sv
design/trapezoid_square_burst_generator.sv
tb/trapezoid_square_burst_generator_tb.sv
